// ===== hw/rtl/tdcp_pkg.sv =====
`timescale 1ns / 1ps

package tdcp_pkg;

   localparam int SLOT_W    = 5;
   localparam int HEAD_W    = 16;
   localparam int ENTRY_W   = 15;
   localparam int POS_W     = 4;
   localparam int RID_W     = 16;
   localparam int MSS_W     = 14;
   localparam int DEPTH_W   = 4;
   localparam int DPL_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;
   localparam int QDEPTH    = 4;
   localparam int QIDX_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic ACT_DOORBELL   = 1'b0;
   localparam logic ACT_DESCRIPTOR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LLQ_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_LOG2       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCS_LINE_LOG2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPLETION_READY = 2'd3;

   localparam logic [DPL_W-1:0] MAX_LINE_LOG2 = 3'd4;

   typedef enum logic [1:0] {
      KIND_FETCH   = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_DISCARD = 2'd2,
      KIND_IDLE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic              action;
      logic [HEAD_W-1:0] new_tail;
      logic              is_meta;
      logic              ext_ok;
      logic              is_first;
      logic              is_last;
      logic              wants_completion;
      logic [RID_W-1:0]  request_id;
      logic [MSS_W-1:0]  meta_mss;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [ENTRY_W-1:0] fetch_entry;
      logic [POS_W-1:0]   fetch_position;
      logic [SLOT_W-1:0]  buffer_count;
      logic [RID_W-1:0]   done_request_id;
      logic               completion_flag;
      logic [HEAD_W-1:0]  head_after;
      logic [MSS_W-1:0]   active_mss;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic two;
   } push_ctl_type;

   localparam rsp_type IDLE_RSP = '{kind: KIND_IDLE, default: '0};

endpackage

// ===== hw/rtl/tdcp_front.sv =====
`timescale 1ns / 1ps

module tdcp_front #(
   parameter int MAX_BUFFERS         = 19,
   parameter int SLOTS_BEFORE_HEADER = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  tdcp_pkg::req_type                   req,
   input  logic                                csr_we,
   input  logic [tdcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tdcp_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output tdcp_pkg::push_ctl_type              push_ctl,
   output tdcp_pkg::rsp_type                   res0,
   output tdcp_pkg::rsp_type                   res1
);
   import tdcp_pkg::*;

   localparam logic [SLOT_W:0] SBH     = (SLOT_W+1)'(SLOTS_BEFORE_HEADER);
   localparam logic [SLOT_W:0] MAX_S   = (SLOT_W+1)'(MAX_BUFFERS);
   localparam logic [SLOT_W-1:0] MAX_B = SLOT_W'(MAX_BUFFERS);

   logic               llq_ff, cr_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DPL_W-1:0]   dpl_ff;

   logic [HEAD_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, bufs_ff, bufs_in;
   logic              meta_ff, meta_in, first_comp_ff, first_comp_in, await_ff, await_in;
   logic [MSS_W-1:0]  pend_ff, pend_in, saved_ff, saved_in;
   logic [RID_W-1:0]  first_rid_ff, first_rid_in;

   logic [DPL_W-1:0]  pl;
   logic [SLOT_W:0]   slot_cur, slot_inc, used, line_cur, line_inc;
   logic [HEAD_W-1:0] avail, head_done;
   logic [HEAD_W-1:0] entry_mask;
   logic              inc_posted, clear, advance, discard;
   rsp_type           r0, r1;
   logic              two;

   function automatic logic [SLOT_W:0] line_of(input logic [SLOT_W:0] s,
                                               input logic [DPL_W-1:0] p);
      logic [SLOT_W:0] d;
      d = s - SBH;
      if (s < SBH) return '0;
      return (d >> p) + (SLOT_W+1)'(1);
   endfunction

   function automatic logic [POS_W-1:0] pos_of(input logic [SLOT_W:0] s,
                                              input logic [DPL_W-1:0] p);
      logic [SLOT_W:0] d;
      logic [SLOT_W:0] m;
      d = s - SBH;
      m = ((SLOT_W+1)'(1) << p) - (SLOT_W+1)'(1);
      if (s < SBH) return POS_W'(s);
      return POS_W'(d & m);
   endfunction

   function automatic rsp_type fetch_res(input logic [HEAD_W-1:0] base,
                                         input logic [SLOT_W:0] off,
                                         input logic [POS_W-1:0] pos,
                                         input logic [HEAD_W-1:0] mask);
      rsp_type r;
      r = '0;
      r.kind           = KIND_FETCH;
      r.fetch_entry    = ENTRY_W'((base + HEAD_W'(off)) & mask);
      r.fetch_position = pos;
      return r;
   endfunction

   assign pl         = (dpl_ff > MAX_LINE_LOG2) ? MAX_LINE_LOG2 : dpl_ff;
   assign entry_mask = HEAD_W'(((HEAD_W+1)'(1) << depth_ff) - (HEAD_W+1)'(1));
   assign slot_cur   = {1'b0, slot_ff};
   assign slot_inc   = slot_cur + (SLOT_W+1)'(1);
   assign line_cur   = line_of(slot_cur, pl);
   assign line_inc   = line_of(slot_inc, pl);
   assign avail      = tail_ff - head_ff;
   assign inc_posted = HEAD_W'(llq_ff ? line_inc : slot_inc) < avail;
   assign used       = (llq_ff ? line_cur : slot_cur) + (SLOT_W+1)'(1);
   assign head_done  = head_ff + HEAD_W'(used);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      slot_in       = slot_ff;
      bufs_in       = bufs_ff;
      meta_in       = meta_ff;
      pend_in       = pend_ff;
      saved_in      = saved_ff;
      first_rid_in  = first_rid_ff;
      first_comp_in = first_comp_ff;
      await_in      = await_ff;
      r0            = IDLE_RSP;
      r1            = IDLE_RSP;
      two           = 1'b0;
      clear         = 1'b0;
      advance       = 1'b0;
      discard       = 1'b0;
      if (req.action == ACT_DOORBELL) begin
         tail_in  = req.new_tail;
         clear    = 1'b1;
         await_in = 1'b0;
         if (cr_ff && head_ff != req.new_tail) begin
            r0       = fetch_res(head_ff, '0, '0, entry_mask);
            await_in = 1'b1;
         end
      end else if (await_ff) begin
         await_in = 1'b0;
         priority if (req.is_meta) begin
            if (slot_ff != '0 || !req.ext_ok) begin
               discard = 1'b1;
            end else begin
               meta_in = 1'b1;
               pend_in = req.meta_mss;
               advance = 1'b1;
            end
         end else if (bufs_ff == '0 && !meta_ff && !req.is_first) begin
            discard = 1'b1;
         end else if (bufs_ff >= MAX_B) begin
            discard = 1'b1;
         end else begin
            if (bufs_ff == '0) begin
               first_rid_in  = req.request_id;
               first_comp_in = req.wants_completion;
            end
            bufs_in = bufs_ff + SLOT_W'(1);
            if (req.is_last) begin
               // packet closes: report it, then start on the next one if posted
               if (meta_ff) saved_in = pend_ff;
               head_in            = head_done;
               r0.kind            = KIND_DONE;
               r0.buffer_count    = bufs_ff + SLOT_W'(1);
               r0.done_request_id = (bufs_ff == '0) ? req.request_id : first_rid_ff;
               r0.completion_flag = (bufs_ff == '0) ? req.wants_completion
                                                    : first_comp_ff;
               r0.head_after      = head_done;
               r0.active_mss      = meta_ff ? pend_ff : saved_ff;
               clear              = 1'b1;
               if (head_done != tail_ff) begin
                  r1       = fetch_res(head_done, '0, '0, entry_mask);
                  two      = 1'b1;
                  await_in = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
         end
         if (advance) begin
            slot_in = slot_inc[SLOT_W-1:0];
            if (slot_inc > MAX_S || !inc_posted) begin
               discard = 1'b1;
            end else begin
               r0 = llq_ff ? fetch_res(head_ff, line_inc, pos_of(slot_inc, pl), entry_mask)
                           : fetch_res(head_ff, slot_inc, '0, entry_mask);
               await_in = 1'b1;
            end
         end
         if (discard) begin
            head_in       = tail_ff;
            clear         = 1'b1;
            await_in      = 1'b0;
            r0            = '0;
            r0.kind       = KIND_DISCARD;
            r0.head_after = tail_ff;
         end
      end
      if (clear) begin
         slot_in       = '0;
         bufs_in       = '0;
         meta_in       = 1'b0;
         pend_in       = '0;
         first_rid_in  = '0;
         first_comp_in = 1'b0;
      end
      if (two) r1.last_result = 1'b1;
      else     r0.last_result = 1'b1;
   end

   assign push_ctl.push = accept;
   assign push_ctl.two  = two;
   assign res0          = r0;
   assign res1          = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         llq_ff        <= 1'b0;
         depth_ff      <= DEPTH_W'(10);
         dpl_ff        <= DPL_W'(3);
         cr_ff         <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         slot_ff       <= '0;
         bufs_ff       <= '0;
         meta_ff       <= 1'b0;
         pend_ff       <= '0;
         saved_ff      <= '0;
         first_rid_ff  <= '0;
         first_comp_ff <= 1'b0;
         await_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LLQ_MODE:         llq_ff   <= csr_wdata[0];
               CSR_DEPTH_LOG2:       depth_ff <= csr_wdata[DEPTH_W-1:0];
               CSR_DESCS_LINE_LOG2:  dpl_ff   <= csr_wdata[DPL_W-1:0];
               CSR_COMPLETION_READY: cr_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            head_ff       <= head_in;
            tail_ff       <= tail_in;
            slot_ff       <= slot_in;
            bufs_ff       <= bufs_in;
            meta_ff       <= meta_in;
            pend_ff       <= pend_in;
            saved_ff      <= saved_in;
            first_rid_ff  <= first_rid_in;
            first_comp_ff <= first_comp_in;
            await_ff      <= await_in;
         end
      end
   end

endmodule

// ===== hw/rtl/tdcp_queue.sv =====
`timescale 1ns / 1ps

module tdcp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tdcp_pkg::push_ctl_type push_ctl,
   input  tdcp_pkg::rsp_type      res0,
   input  tdcp_pkg::rsp_type      res1,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tdcp_pkg::rsp_type      rsp_data
);
   import tdcp_pkg::*;

   rsp_type           mem [QDEPTH];
   logic [QIDX_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              pop;
   logic [QCNT_W-1:0] n_push;

   assign pop       = rsp_valid && !rsp_stall;
   assign n_push    = push_ctl.push ? (push_ctl.two ? QCNT_W'(2) : QCNT_W'(1)) : '0;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem[rd_ff];
   // two free entries are needed since one item can cause two results
   assign room      = count_ff <= QCNT_W'(QDEPTH - 2);

   always_ff @(posedge clock) begin
      if (push_ctl.push) begin
         mem[wr_ff] <= res0;
         if (push_ctl.two) mem[wr_ff + QIDX_W'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + QIDX_W'(n_push);
         if (pop) rd_ff <= rd_ff + QIDX_W'(1);
         count_ff <= count_ff + n_push - (pop ? QCNT_W'(1) : QCNT_W'(0));
      end
   end

endmodule

// ===== hw/rtl/tx_descriptor_chain_parser_core.sv =====
`timescale 1ns / 1ps

// Transmit submission-queue walker. Doorbells set the tail; fetched descriptors
// are checked and each transfer on the req_ side gives one or two rsp_ transfers
// (fetch request, packet done, burst discarded or idle, last_result marks the
// final one). An item is decided in the cycle it is accepted and its results
// appear on rsp_ in queue order. The front takes one item per cycle as long
// as the four-entry result queue has two free entries; the single result port
// drains one result per cycle while rsp_stall is low, so items that cause two
// results set the pace. Configuration writes take effect at the next clock edge.
module tx_descriptor_chain_parser_core #(
   parameter int MAX_BUFFERS         = 19,
   parameter int SLOTS_BEFORE_HEADER = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tdcp_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tdcp_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [tdcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tdcp_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import tdcp_pkg::*;

   push_ctl_type push_ctl;
   rsp_type      res0, res1;
   logic         room;
   logic         accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   tdcp_front #(
      .MAX_BUFFERS         (MAX_BUFFERS),
      .SLOTS_BEFORE_HEADER (SLOTS_BEFORE_HEADER)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push_ctl  (push_ctl),
      .res0      (res0),
      .res1      (res1)
   );

   tdcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_ctl  (push_ctl),
      .res0      (res0),
      .res1      (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tx_descriptor_chain_parser_core_tb.sv =====
`timescale 1ns / 1ps

module tx_descriptor_chain_parser_core_tb;
   import tdcp_pkg::*;

   localparam int MAX_BUFS     = 19;
   localparam int HEADER_SLOTS = 2;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 150;
   localparam int NUM_PHASES   = 6;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   tx_descriptor_chain_parser_core #(
      .MAX_BUFFERS         (MAX_BUFS),
      .SLOTS_BEFORE_HEADER (HEADER_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // walker model state
   logic              cfg_llq;
   logic [DEPTH_W-1:0] cfg_depth;
   logic [DPL_W-1:0]  cfg_dpl;
   logic              cfg_comp;
   logic [HEAD_W-1:0] q_head;
   logic [HEAD_W-1:0] q_tail;
   logic [SLOT_W-1:0] cur_slot;
   logic [SLOT_W-1:0] bufs_seen;
   logic              meta_found;
   logic [MSS_W-1:0]  pend_mss;
   logic [MSS_W-1:0]  held_mss;
   logic [RID_W-1:0]  head_rid;
   logic              head_comp;
   bit                fetch_pending;

   rsp_type walk_results[$];
   rsp_type pending_rsps[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int holds_served;
   int hold_left;
   int mismatches;
   int cycles;
   int packet_bufs;

   function automatic int line_log2();
      return (cfg_dpl > MAX_LINE_LOG2) ? int'(MAX_LINE_LOG2) : int'(cfg_dpl);
   endfunction

   function automatic int slot_line(int s);
      if (s < HEADER_SLOTS) return 0;
      return 1 + ((s - HEADER_SLOTS) >> line_log2());
   endfunction

   function automatic int slot_pos(int s);
      if (s < HEADER_SLOTS) return s;
      return (s - HEADER_SLOTS) & ((1 << line_log2()) - 1);
   endfunction

   function automatic bit slot_posted(int s);
      logic [HEAD_W-1:0] avail;
      avail = q_tail - q_head;
      return (cfg_llq ? slot_line(s) : s) < int'(avail);
   endfunction

   function automatic rsp_type make_rsp(kind_type k, int entry, int pos, int cnt, int rid,
                                        int comp, int head, int mss);
      rsp_type r;
      r = '0;
      r.kind            = k;
      r.fetch_entry     = entry[ENTRY_W-1:0];
      r.fetch_position  = pos[POS_W-1:0];
      r.buffer_count    = cnt[SLOT_W-1:0];
      r.done_request_id = rid[RID_W-1:0];
      r.completion_flag = comp[0];
      r.head_after      = head[HEAD_W-1:0];
      r.active_mss      = mss[MSS_W-1:0];
      r.last_result     = 1'b1;
      return r;
   endfunction

   function automatic void clear_walk();
      cur_slot   = '0;
      bufs_seen  = '0;
      meta_found = 1'b0;
      pend_mss   = '0;
      head_rid   = '0;
      head_comp  = 1'b0;
   endfunction

   function automatic void emit_fetch();
      int mask;
      int line;
      mask = (1 << cfg_depth) - 1;
      line = cfg_llq ? slot_line(int'(cur_slot)) : int'(cur_slot);
      walk_results.push_back(make_rsp(KIND_FETCH, (int'(q_head) + line) & mask,
                                      cfg_llq ? slot_pos(int'(cur_slot)) : 0,
                                      0, 0, 0, 0, 0));
      fetch_pending = 1'b1;
   endfunction

   function automatic void emit_discard();
      q_head = q_tail;
      clear_walk();
      fetch_pending = 1'b0;
      walk_results.push_back(make_rsp(KIND_DISCARD, 0, 0, 0, 0, 0, int'(q_head), 0));
   endfunction

   function automatic void walk_reset();
      cfg_llq   = 1'b0;
      cfg_depth = 4'd10;
      cfg_dpl   = 3'd3;
      cfg_comp  = 1'b0;
      q_head    = '0;
      q_tail    = '0;
      held_mss  = '0;
      clear_walk();
      fetch_pending = 1'b0;
   endfunction

   function automatic void walk_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_LLQ_MODE:         cfg_llq   = val[0];
         CSR_DEPTH_LOG2:       cfg_depth = val[DEPTH_W-1:0];
         CSR_DESCS_LINE_LOG2:  cfg_dpl   = val[DPL_W-1:0];
         CSR_COMPLETION_READY: cfg_comp  = val[0];
         default: ;
      endcase
   endfunction

   // fills walk_results with what one accepted item causes
   function automatic void walk_step(req_type it);
      bit advance;
      int used;
      walk_results.delete();
      advance = 1'b0;
      if (it.action == ACT_DOORBELL) begin
         q_tail = it.new_tail;
         clear_walk();
         fetch_pending = 1'b0;
         if (cfg_comp && q_head != q_tail) emit_fetch();
         else walk_results.push_back(make_rsp(KIND_IDLE, 0, 0, 0, 0, 0, 0, 0));
      end else if (!fetch_pending) begin
         walk_results.push_back(make_rsp(KIND_IDLE, 0, 0, 0, 0, 0, 0, 0));
      end else begin
         fetch_pending = 1'b0;
         if (it.is_meta) begin
            if (cur_slot != 0 || !it.ext_ok) begin
               emit_discard();
            end else begin
               meta_found = 1'b1;
               pend_mss   = it.meta_mss;
               advance    = 1'b1;
            end
         end else if (bufs_seen == 0 && !meta_found && !it.is_first) begin
            emit_discard();
         end else if (bufs_seen >= MAX_BUFS) begin
            emit_discard();
         end else begin
            if (bufs_seen == 0) begin
               head_rid  = it.request_id;
               head_comp = it.wants_completion;
            end
            bufs_seen = bufs_seen + 1'b1;
            if (it.is_last) begin
               used = cfg_llq ? slot_line(int'(cur_slot)) + 1 : int'(cur_slot) + 1;
               if (meta_found) held_mss = pend_mss;
               q_head = q_head + used[HEAD_W-1:0];
               walk_results.push_back(make_rsp(KIND_DONE, 0, 0, int'(bufs_seen),
                                               int'(head_rid), int'(head_comp),
                                               int'(q_head), int'(held_mss)));
               clear_walk();
               if (q_head != q_tail) emit_fetch();
            end else begin
               advance = 1'b1;
            end
         end
      end
      if (advance) begin
         cur_slot = cur_slot + 1'b1;
         if (cur_slot > MAX_BUFS || !slot_posted(int'(cur_slot))) emit_discard();
         else emit_fetch();
      end
      foreach (walk_results[i]) walk_results[i].last_result = 1'b0;
      walk_results[walk_results.size()-1].last_result = 1'b1;
   endfunction

   function automatic req_type mk_bell(int tail);
      req_type it;
      it = '0;
      it.action   = ACT_DOORBELL;
      it.new_tail = tail[HEAD_W-1:0];
      return it;
   endfunction

   function automatic req_type mk_desc(int meta, int ext, int first, int last, int comp,
                                       int rid, int mss);
      req_type it;
      it = '0;
      it.action           = ACT_DESCRIPTOR;
      it.is_meta          = meta[0];
      it.ext_ok           = ext[0];
      it.is_first         = first[0];
      it.is_last          = last[0];
      it.wants_completion = comp[0];
      it.request_id       = rid[RID_W-1:0];
      it.meta_mss         = mss[MSS_W-1:0];
      return it;
   endfunction

   // mostly well-formed packets against the walk in progress, with some noise
   function automatic req_type next_item();
      req_type it;
      int r;
      it.action           = ACT_DESCRIPTOR;
      it.new_tail         = HEAD_W'($urandom);
      it.is_meta          = 1'($urandom);
      it.ext_ok           = 1'($urandom);
      it.is_first         = 1'($urandom);
      it.is_last          = 1'($urandom);
      it.wants_completion = 1'($urandom);
      it.request_id       = RID_W'($urandom);
      it.meta_mss         = MSS_W'($urandom);
      r = $urandom_range(99);
      if (!fetch_pending || r < 4) begin
         if (!fetch_pending && $urandom_range(9) == 0) return it;
         it.action = ACT_DOORBELL;
         case ($urandom_range(9))
            0: it.new_tail = q_head;
            1: ;
            default: it.new_tail = q_head + HEAD_W'($urandom_range(48, 1));
         endcase
      end else if (r >= 12) begin
         if (cur_slot == 0 && bufs_seen == 0 && !meta_found) begin
            packet_bufs = ($urandom_range(7) == 0) ? $urandom_range(21, 15)
                                                   : $urandom_range(4, 1);
            if ($urandom_range(2) == 0) begin
               it.is_meta = 1'b1;
               it.ext_ok  = 1'b1;
               return it;
            end
         end
         it.is_meta = 1'b0;
         if (bufs_seen == 0 && !meta_found) it.is_first = 1'b1;
         it.is_last = (int'(bufs_seen) + 1 >= packet_bufs);
      end
      return it;
   endfunction

   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      walk_step(it);
      if (typed) pending_rsps.push_back(want);
      else foreach (walk_results[i]) pending_rsps.push_back(walk_results[i]);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      walk_config(idx, val);
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected rsp transfer: kind=%0d entry=%0d pos=%0d", rsp_data.kind,
                        rsp_data.fetch_entry, rsp_data.fetch_position);
            mismatches <= mismatches + 1;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.fetch_entry !== want.fetch_entry ||
                rsp_data.fetch_position !== want.fetch_position ||
                rsp_data.buffer_count !== want.buffer_count ||
                rsp_data.done_request_id !== want.done_request_id ||
                rsp_data.completion_flag !== want.completion_flag ||
                rsp_data.head_after !== want.head_after ||
                rsp_data.active_mss !== want.active_mss ||
                rsp_data.last_result !== want.last_result) begin
               if (mismatches < 10) begin
                  $display("rsp mismatch at %0t", $realtime);
                  $display({"  exp kind=%0d entry=%0d pos=%0d cnt=%0d rid=%0h comp=%0d",
                            " head=%0h mss=%0d last=%0d"},
                           want.kind, want.fetch_entry, want.fetch_position,
                           want.buffer_count, want.done_request_id, want.completion_flag,
                           want.head_after, want.active_mss, want.last_result);
                  $display({"  got kind=%0d entry=%0d pos=%0d cnt=%0d rid=%0h comp=%0d",
                            " head=%0h mss=%0d last=%0d"},
                           rsp_data.kind, rsp_data.fetch_entry, rsp_data.fetch_position,
                           rsp_data.buffer_count, rsp_data.done_request_id,
                           rsp_data.completion_flag, rsp_data.head_after,
                           rsp_data.active_mss, rsp_data.last_result);
               end
               mismatches <= mismatches + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] val;
      req_type              item;
      bit                   typed;
      rsp_type              want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void add_item(req_type it);
      dir_row_type row;
      row = '{is_csr: 1'b0, idx: '0, val: '0, item: it, typed: 1'b0, want: '0};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(req_type it, rsp_type want);
      dir_row_type row;
      row = '{is_csr: 1'b0, idx: '0, val: '0, item: it, typed: 1'b1, want: want};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      dir_row_type row;
      row = '{is_csr: 1'b1, idx: idx, val: val, item: '0, typed: 1'b0, want: '0};
      dir_rows.push_back(row);
   endfunction

   function automatic rsp_type idle_rsp();
      return make_rsp(KIND_IDLE, 0, 0, 0, 0, 0, 0, 0);
   endfunction

   function automatic rsp_type fetch_rsp(int entry, int pos);
      return make_rsp(KIND_FETCH, entry, pos, 0, 0, 0, 0, 0);
   endfunction

   function automatic rsp_type discard_rsp(int head);
      return make_rsp(KIND_DISCARD, 0, 0, 0, 0, 0, head, 0);
   endfunction

   initial begin
      int ph_llq[NUM_PHASES];
      int ph_depth[NUM_PHASES];
      int ph_dpl[NUM_PHASES];
      int ph_comp[NUM_PHASES];
      int ph_items[NUM_PHASES];
      int ph_send[NUM_PHASES];
      int ph_recv[NUM_PHASES];
      int count;
      req_type it;

      ph_llq   = '{0, 1, 1, 1, 0, 1};
      ph_depth = '{15, 3, 15, 1, 1, 8};
      ph_dpl   = '{3, 2, 4, 7, 5, 3};
      ph_comp  = '{1, 1, 1, 1, 0, 1};
      ph_items = '{200, 150, 150, 100, 50, 200};
      ph_send  = '{21, 21, 67, 67, 0, 0};
      ph_recv  = '{67, 67, 21, 21, 0, 0};

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      send_idle_pct = 21;
      recv_idle_pct = 67;
      hold_requests = 0;
      holds_served  = 0;
      mismatches    = 0;
      cycles        = 0;
      packet_bufs   = 1;
      walk_reset();

      // directed walk: disabled queue, packets with meta, discards for bad meta, missing first and unposted slot, wrap
      add_typed(mk_bell(5), idle_rsp());
      add_typed(mk_desc(1, 1, 1, 1, 1, 16'hffff, 14'h3fff), idle_rsp());
      add_csr(CSR_COMPLETION_READY, 4'd1);
      add_typed(mk_bell(5), fetch_rsp(0, 0));
      add_item(mk_desc(1, 1, 0, 0, 0, 0, 14'h3fff));
      add_item(mk_desc(0, 0, 1, 0, 1, 16'hffff, 0));
      add_item(mk_desc(0, 0, 0, 1, 0, 0, 0));
      add_typed(mk_bell(5), fetch_rsp(3, 0));
      add_item(mk_desc(0, 0, 1, 0, 0, 16'h1234, 0));
      add_typed(mk_desc(1, 1, 0, 0, 0, 0, 0), discard_rsp(5));
      add_typed(mk_bell(5), idle_rsp());
      add_typed(mk_bell(7), fetch_rsp(5, 0));
      add_typed(mk_desc(0, 0, 0, 1, 1, 16'hffff, 14'h3fff), discard_rsp(7));
      add_typed(mk_bell(9), fetch_rsp(7, 0));
      add_typed(mk_desc(1, 0, 0, 0, 0, 0, 100), discard_rsp(9));
      add_typed(mk_bell(10), fetch_rsp(9, 0));
      add_typed(mk_desc(0, 0, 1, 0, 0, 0, 0), discard_rsp(10));
      add_typed(mk_bell(16'hffff), fetch_rsp(10, 0));
      add_item(mk_desc(0, 0, 1, 1, 0, 0, 0));
      add_csr(CSR_COMPLETION_READY, 4'd0);
      add_typed(mk_bell(0), idle_rsp());
      add_csr(CSR_COMPLETION_READY, 4'd1);
      add_csr(CSR_LLQ_MODE, 4'd1);
      add_csr(CSR_DEPTH_LOG2, 4'd1);
      add_csr(CSR_DESCS_LINE_LOG2, 4'd2);
      add_typed(mk_bell(0), fetch_rsp(1, 0));
      add_item(mk_desc(0, 0, 1, 0, 1, 16'h8001, 0));
      add_item(mk_desc(0, 0, 0, 0, 0, 0, 0));
      add_item(mk_desc(0, 0, 0, 1, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) write_csr(dir_rows[i].idx, dir_rows[i].val);
         else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_LLQ_MODE, CSR_DAT_W'(ph_llq[p]));
         write_csr(CSR_DEPTH_LOG2, CSR_DAT_W'(ph_depth[p]));
         write_csr(CSR_DESCS_LINE_LOG2, CSR_DAT_W'(ph_dpl[p]));
         write_csr(CSR_COMPLETION_READY, CSR_DAT_W'(ph_comp[p]));
         send_idle_pct = ph_send[p];
         recv_idle_pct = ph_recv[p];
         // long receiver hold-off while items keep coming
         if (p == NUM_PHASES - 1) hold_requests = hold_requests + 1;
         count = 0;
         while (count < ph_items[p]) begin
            it = next_item();
            if (it.action == ACT_DOORBELL || fetch_pending) count++;
            send_item(it, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tdcp_pkg.sv
hw/rtl/tdcp_front.sv
hw/rtl/tdcp_queue.sv
hw/rtl/tx_descriptor_chain_parser_core.sv
tb/tx_descriptor_chain_parser_core_tb.sv
